// ===== rtl/core/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

  // Fixed field widths of the command and result ports
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic [0:0] {
    FUNC_LOOKUP = 1'b0,
    FUNC_STORE  = 1'b1
  } func_t;

endpackage : lkvc_pkg

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
//
// Command channel: func/key/value are taken on a rising edge with start high and
// busy low. busy is never raised, so one command can be issued every cycle.
// func selects a lookup or a store. Only the low KEY_BITS bits of key are compared.
//
// Result channel: one result per command, on hit/value_out/evicted/occupancy while
// done is high for a single cycle. The receiver cannot stall; each result is a
// transfer in the cycle it appears. An accepted command passes the input register,
// then the result register / value RAM read, and done rises with the result;
// throughput is one command per cycle, set by the tag compare and recency update.
//
// Reset (rst, synchronous) clears all valid bits, recency ranks and the entry
// count; tags and values are left as they are and are only ever read through a
// valid entry. No clearing pass is needed, commands are taken right after reset.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [0:0]        func,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [DATA_W-1:0] value,
  output logic                   done,
  output logic                   hit,
  output logic      [DATA_W-1:0] value_out,
  output logic                   evicted,
  output logic      [OCC_W-1:0]  occupancy
);

  localparam int TAG_W  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int RANK_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // ---------------- input register ----------------
  logic              in_vld;
  func_t             in_func;
  logic [TAG_W-1:0]  in_key;
  logic [DATA_W-1:0] in_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_func  <= func_t'(func);
      in_key   <= key[TAG_W-1:0];
      in_value <= value;
    end
  end

  // ---------------- entry state ----------------
  logic [TAG_W-1:0]  tag   [CAPACITY];
  logic [RANK_W-1:0] rank  [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // ---------------- compare and slot select ----------------
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] lru_sel;
  logic                key_hit;
  logic                full;
  logic [IDX_W-1:0]    hit_slot;
  logic [RANK_W-1:0]   hit_rank;
  logic [IDX_W-1:0]    lru_slot;
  logic [IDX_W-1:0]    free_slot;
  logic [IDX_W-1:0]    slot;
  logic                is_store;
  logic                do_insert;
  logic                do_promote;
  logic                do_evict;

  always_comb begin
    hit_slot  = '0;
    hit_rank  = '0;
    lru_slot  = '0;
    free_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]   = valid[i] && (tag[i] == in_key);
      // when full the ranks are a permutation, so exactly one entry holds the last rank
      lru_sel[i] = valid[i] && (rank[i] == RANK_W'(CAPACITY - 1));
      if (match[i]) begin
        hit_slot = hit_slot | IDX_W'(i);
        hit_rank = hit_rank | rank[i];
      end
      if (lru_sel[i]) begin
        lru_slot = lru_slot | IDX_W'(i);
      end
    end
    // lowest-numbered empty slot
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  assign key_hit    = |match;
  assign full       = (count == CNT_W'(CAPACITY));
  assign is_store   = in_vld && (in_func == FUNC_STORE);
  assign do_insert  = is_store && !key_hit;
  assign do_evict   = do_insert && full;
  assign do_promote = in_vld && key_hit || do_insert;

  always_comb begin
    priority if (key_hit) begin
      slot = hit_slot;
    end else if (full) begin
      slot = lru_slot;
    end else begin
      slot = free_slot;
    end
  end

  assign count_next = (do_insert && !full) ? count + 1'b1 : count;

  // ---------------- state update ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank[i] <= '0;
      end
    end else begin
      count <= count_next;
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_promote) begin
          if (slot == IDX_W'(i)) begin
            rank[i] <= '0;
          end else if (valid[i] && (do_insert || rank[i] < hit_rank)) begin
            // insert ages every other entry; a hit ages only the more recent ones
            rank[i] <= rank[i] + 1'b1;
          end
        end
        if (do_insert && slot == IDX_W'(i)) begin
          valid[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_insert && slot == IDX_W'(i)) begin
        tag[i] <= in_key;
      end
    end
  end

  // ---------------- value store ----------------
  logic [DATA_W-1:0] rd_data;

  lkvc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (is_store),
    .waddr (slot),
    .wdata (in_value),
    .raddr (hit_slot),
    .rdata (rd_data)
  );

  // ---------------- result register ----------------
  logic lookup_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    hit        <= key_hit;
    evicted    <= do_evict;
    lookup_hit <= in_vld && key_hit && (in_func == FUNC_LOOKUP);
    occupancy  <= OCC_W'(count_next);
  end

  assign value_out = lookup_hit ? rd_data : '0;

  // commands never wait
  assign busy = 1'b0;

  // ---------------- assertions ----------------
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("entry count disagrees with valid bits");

  a_unique_key: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key present in more than one entry");

  a_one_victim: assert property (@(posedge clk) disable iff (rst)
    full |-> $onehot(lru_sel))
    else $error("full cache without a single least recent entry");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    done && evicted |-> !hit && occupancy == OCC_W'(CAPACITY))
    else $error("eviction reported on a hit or below capacity");

endmodule : lru_key_value_cache

`default_nettype wire

// ===== rtl/core/lkvc_ram.sv =====
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : lkvc_ram

`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
  import lkvc_pkg::*;

  // Block configuration under test
  localparam int LRU_DEPTH = 16;
  localparam int TAG_BITS  = 32;

  // Run limits: worst case is every transfer behind the longest idle gap, plus the
  // result pipeline; the limit is many times that.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 700;
  localparam int KEY_POOL     = 24;  // more keys than entries, so evictions happen

  // One command as queued for the driver, with the idle time before it
  typedef struct {
    func_t       op;
    logic [31:0] k;
    logic [31:0] v;
    int          gap;
  } cache_cmd_t;

  // One result as the block reports it
  typedef struct {
    logic        hit;
    logic [31:0] value_out;
    logic        evicted;
    logic [4:0]  occupancy;
  } cache_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  func_t                 func = FUNC_LOOKUP;
  logic [KEY_W-1:0]      key = '0;
  logic [DATA_W-1:0]     value = '0;
  logic                  done;
  logic                  hit;
  logic [DATA_W-1:0]     value_out;
  logic                  evicted;
  logic [OCC_W-1:0]      occupancy;

  lru_key_value_cache #(
    .CAPACITY(LRU_DEPTH),
    .KEY_BITS(TAG_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .key(key),
    .value(value),
    .done(done),
    .hit(hit),
    .value_out(value_out),
    .evicted(evicted),
    .occupancy(occupancy)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache contents, kept in step with accepted commands.
  // Rank 0 is the most recent entry, count-1 the least recent.
  // ---------------------------------------------------------------------------
  logic [63:0] shadow_key  [LRU_DEPTH];
  logic [31:0] shadow_val  [LRU_DEPTH];
  bit          shadow_vld  [LRU_DEPTH];
  int          shadow_rank [LRU_DEPTH];
  int          shadow_count;

  // Bring slot s to the front; valid entries ranked below limit age by one.
  function automatic void bump_to_front(int s, int limit);
    for (int i = 0; i < LRU_DEPTH; i++)
      if (shadow_vld[i] && i != s && shadow_rank[i] < limit)
        shadow_rank[i]++;
    shadow_rank[s] = 0;
  endfunction

  // Apply one command to the shadow cache and return the result it must give.
  function automatic cache_result_t cache_access(func_t op, logic [31:0] k,
                                                 logic [31:0] v);
    cache_result_t r;
    logic [63:0]   tag;
    int            slot;
    int            worst;
    bit            found;
    tag   = {32'd0, k} & ((64'd1 << TAG_BITS) - 64'd1);
    r     = '{hit: 1'b0, value_out: '0, evicted: 1'b0, occupancy: '0};
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < LRU_DEPTH; i++)
      if (!found && shadow_vld[i] && shadow_key[i] == tag) begin
        found = 1'b1;
        slot  = i;
      end
    if (found) begin
      // Hit: lookup reads, store overwrites; either way it becomes most recent
      r.hit = 1'b1;
      if (op == FUNC_LOOKUP)
        r.value_out = shadow_val[slot];
      else
        shadow_val[slot] = v;
      bump_to_front(slot, shadow_rank[slot]);
    end else if (op == FUNC_STORE) begin
      if (shadow_count >= LRU_DEPTH) begin
        // Full: reuse the slot of the oldest valid entry
        worst = -1;
        for (int i = 0; i < LRU_DEPTH; i++)
          if (shadow_vld[i] && shadow_rank[i] > worst) begin
            worst = shadow_rank[i];
            slot  = i;
          end
        shadow_vld[slot] = 1'b0;
        shadow_count--;
        r.evicted = 1'b1;
      end else begin
        // Room left: lowest free slot
        found = 1'b0;
        for (int i = 0; i < LRU_DEPTH; i++)
          if (!found && !shadow_vld[i]) begin
            found = 1'b1;
            slot  = i;
          end
      end
      shadow_key[slot] = tag;
      shadow_val[slot] = v;
      bump_to_front(slot, LRU_DEPTH);
      shadow_vld[slot] = 1'b1;
      shadow_count++;
    end
    // A lookup miss changes nothing
    r.occupancy = shadow_count[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue and idle-gap generation
  // ---------------------------------------------------------------------------
  cache_cmd_t    cmd_q[$];
  cache_result_t result_q[$];   // expected results, oldest first
  int            total_cmds = 0;
  int            accepted_cmds = 0;
  int            fail_count = 0;
  int            burst_left = 0;
  logic [31:0]   key_pool [KEY_POOL];

  // Queue a command. Idle gaps are random, with occasional back-to-back bursts.
  task automatic queue_cmd(func_t op, logic [31:0] k, logic [31:0] v);
    cache_cmd_t c;
    if (burst_left == 0 && $urandom_range(0, 7) == 0)
      burst_left = $urandom_range(5, 30);
    c.op  = op;
    c.k   = k;
    c.v   = v;
    if (burst_left > 0) begin
      c.gap = 0;
      burst_left--;
    end else begin
      c.gap = $urandom_range(0, 19);
    end
    cmd_q.push_back(c);
    total_cmds++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. A transfer took place at the
  // previous rising edge if start was high and busy low (xfer_seen).
  // ---------------------------------------------------------------------------
  logic       xfer_seen = 1'b0;
  cache_cmd_t next_cmd;
  bit         next_ready = 1'b0;
  int         idle_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || xfer_seen) begin
      if (!next_ready && cmd_q.size() > 0) begin
        next_cmd   = cmd_q.pop_front();
        next_ready = 1'b1;
        idle_left  = next_cmd.gap;
      end
      if (next_ready && idle_left == 0) begin
        // start stays high across back-to-back transfers, one assignment per edge
        start      <= 1'b1;
        func       <= next_cmd.op;
        key        <= next_cmd.k;
        value      <= next_cmd.v;
        next_ready = 1'b0;
      end else begin
        start <= 1'b0;
        if (next_ready)
          idle_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on the rising edge, check any result against the oldest expected
  // one, then predict the result of a command accepted at this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    cache_result_t want;
    if (rst) begin
      xfer_seen <= 1'b0;
    end else begin
      xfer_seen <= start && !busy;
      if (done) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: hit=%0d value_out=%h evicted=%0d occupancy=%0d",
                 hit, value_out, evicted, occupancy);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            fail_count++;
          end
          if (value_out !== want.value_out) begin
            $error("value_out: expected %h, got %h", want.value_out, value_out);
            fail_count++;
          end
          if (evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, evicted);
            fail_count++;
          end
          if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        result_q.push_back(cache_access(func, key, value));
        accepted_cmds++;
      end
    end
  end

  // Watchdog
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    func_t op;
    logic [31:0] k;
    for (int i = 0; i < LRU_DEPTH; i++) begin
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_vld[i]  = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_count = 0;

    // Directed: empty lookup, extreme keys/values, store hit, fill, eviction,
    // miss on a full cache, store hit on a full cache.
    queue_cmd(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_cmd(FUNC_STORE,  32'h0000_0000, 32'h0000_0000);
    queue_cmd(FUNC_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_cmd(FUNC_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    queue_cmd(FUNC_STORE,  32'h0000_0000, 32'hA5A5_5A5A);
    queue_cmd(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    for (int i = 1; i <= LRU_DEPTH - 2; i++)
      queue_cmd(FUNC_STORE, i, $urandom);
    queue_cmd(FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    queue_cmd(FUNC_STORE,  32'h0000_0100, 32'hDEAD_BEEF);  // evicts oldest
    queue_cmd(FUNC_LOOKUP, 32'h1234_5678, 32'h0000_0000);  // miss when full
    queue_cmd(FUNC_STORE,  32'h0000_0000, 32'h5A5A_A5A5);  // hit when full

    // Random: mostly keys from a small pool so hits, overwrites and
    // evictions are common; some fully random keys as noise.
    for (int i = 0; i < KEY_POOL; i++)
      key_pool[i] = $urandom;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      op = ($urandom_range(0, 1) == 0) ? FUNC_LOOKUP : FUNC_STORE;
      if ($urandom_range(0, 4) == 0)
        k = $urandom;
      else
        k = key_pool[$urandom_range(0, KEY_POOL - 1)];
      queue_cmd(op, k, $urandom);
    end

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_cmds < total_cmds)
      @(posedge clk);
    while (result_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ram.sv
rtl/core/lru_key_value_cache.sv
sim/tb_top.sv
